// File: hdl/morse_paddle_keyer_assert.svh
// Assertion macros shared by the Morse keyer RTL.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef MORSE_PADDLE_KEYER_ASSERT_SVH
`define MORSE_PADDLE_KEYER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPK_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MPK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/mpk_pkg.sv
// Types and constants for the Morse paddle keyer.
// No dependencies; used by morse_paddle_keyer.
package mpk_pkg;

   typedef enum logic {
      CMD_TICK = 1'b0,
      CMD_KNOB = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_MIN_GAP          = 2'd0,
      CSR_RELEASE_HOLD     = 2'd1,
      CSR_DEBOUNCE_TICKS   = 2'd2,
      CSR_TONE_HALF_PERIOD = 2'd3
   } csr_index_type;

   localparam int CSR_DATA_W = 12;

   typedef struct packed {
      cmd_type    command;
      logic       dot_paddle;
      logic       dash_paddle;
      logic       mode_button;
      logic [9:0] knob_sample;
   } req_payload_type;

   typedef struct packed {
      logic        key_down;
      logic        auto_mode;
      logic [11:0] tone_compare;
      logic [5:0]  dot_length;
   } rsp_payload_type;

   localparam logic [7:0]  MIN_GAP_RST          = 8'd30;
   localparam logic [7:0]  RELEASE_HOLD_RST     = 8'd10;
   localparam logic [7:0]  DEBOUNCE_TICKS_RST   = 8'd100;
   localparam logic [11:0] TONE_HALF_PERIOD_RST = 12'd1812;
   localparam logic [5:0]  DOT_TICKS_RST        = 6'd50;
   localparam logic [7:0]  DASH_TICKS_RST       = 8'd150;
   localparam logic [5:0]  DOT_BASE             = 6'd30;
   localparam logic [11:0] TONE_FLOOR           = 12'd1;

endpackage

// File: hdl/morse_paddle_keyer.sv
// Morse paddle keyer: tick-driven dot/dash timing, manual keying and knob control.
// Depends on mpk_pkg and morse_paddle_keyer_assert.svh.
//
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_ready      mpk_pkg::req_payload_type
//   rsp_      out        rsp_valid / rsp_ready      mpk_pkg::rsp_payload_type
//   csr_      in         csr_we, no handshake       csr_addr, csr_wdata
//
// The result of each request is registered at the accepting edge and
// shown from the next cycle. The keyer state updates once per request, so one
// request a cycle is sustained. A held result stalls the input only while rsp_ready
// is low. Reset is synchronous and restores the CSR registers and all keyer state.
module morse_paddle_keyer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  mpk_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output mpk_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_we,
   input  mpk_pkg::csr_index_type        csr_addr,
   input  logic [mpk_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mpk_pkg::*;

`include "morse_paddle_keyer_assert.svh"

   logic [7:0]  min_gap_ff, release_hold_ff, debounce_ticks_ff;
   logic [11:0] tone_half_period_ff;

   logic [7:0]  on_count_ff, on_count_in;
   logic [7:0]  off_count_ff, off_count_in;
   logic        element_running_ff, element_running_in;
   logic        auto_flag_ff, auto_flag_in;
   logic [5:0]  dot_ticks_ff, dot_ticks_in;
   logic [7:0]  dash_ticks_ff, dash_ticks_in;
   logic        button_level_ff, button_level_in;
   logic [7:0]  debounce_count_ff, debounce_count_in;
   logic        gate_on_ff, gate_on_in;
   logic [11:0] tone_value_ff, tone_value_in;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff;

   logic        req_accept;
   logic [10:0] knob_double;
   logic [11:0] tone_knob;
   logic [5:0]  dot_knob;
   logic [7:0]  dash_knob;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_ready);

   // Knob mapping: tone value floors at one, dot length spans 30 to 61 ticks.
   assign knob_double = {req_payload.knob_sample, 1'b0};
   assign tone_knob   = (tone_half_period_ff > {1'b0, knob_double})
                        ? (tone_half_period_ff - {1'b0, knob_double}) : TONE_FLOOR;
   assign dot_knob    = {1'b0, req_payload.knob_sample[9:5]} + DOT_BASE;
   assign dash_knob   = {1'b0, dot_knob, 1'b0} + {2'b00, dot_knob};

   always_comb begin
      logic       lvl_v, auto_v, gate_v, run_v, any_v;
      logic [7:0] deb_v, on_v, off_v;

      on_count_in        = on_count_ff;
      off_count_in       = off_count_ff;
      element_running_in = element_running_ff;
      auto_flag_in       = auto_flag_ff;
      dot_ticks_in       = dot_ticks_ff;
      dash_ticks_in      = dash_ticks_ff;
      button_level_in    = button_level_ff;
      debounce_count_in  = debounce_count_ff;
      gate_on_in         = gate_on_ff;
      tone_value_in      = tone_value_ff;

      lvl_v  = button_level_ff;
      deb_v  = debounce_count_ff;
      auto_v = auto_flag_ff;
      gate_v = gate_on_ff;
      run_v  = element_running_ff;
      on_v   = on_count_ff;
      off_v  = off_count_ff;
      any_v  = !req_payload.dot_paddle || !req_payload.dash_paddle;

      if (req_payload.command == CMD_KNOB) begin
         if (!auto_flag_ff) begin
            tone_value_in = tone_knob;
         end else begin
            dot_ticks_in  = dot_knob;
            dash_ticks_in = dash_knob;
         end
      end else begin
         // Debounce the mode button; a press that gets through toggles the mode.
         if ((req_payload.mode_button != lvl_v) && (deb_v == 8'd0)) begin
            deb_v = debounce_ticks_ff;
            lvl_v = req_payload.mode_button;
            if (!lvl_v) begin
               auto_v = !auto_v;
            end
         end
         if (deb_v != 8'd0) begin
            deb_v = deb_v - 8'd1;
         end

         if (auto_v) begin
            if (!run_v) begin
               if (!req_payload.dot_paddle) begin
                  on_v  = {2'b00, dot_ticks_ff};
                  run_v = 1'b1;
               end else if (!req_payload.dash_paddle) begin
                  on_v  = dash_ticks_ff;
                  run_v = 1'b1;
               end
            end
            if (on_v != 8'd0) begin
               gate_v = 1'b1;
               on_v   = on_v - 8'd1;
               if (on_v == 8'd0) begin
                  off_v = {2'b00, dot_ticks_ff};
               end
            end else begin
               gate_v = 1'b0;
            end
            if (off_v != 8'd0) begin
               off_v = off_v - 8'd1;
               if (off_v == 8'd0) begin
                  run_v = 1'b0;
               end
            end
         end else begin
            if (off_v != 8'd0) begin
               off_v = off_v - 8'd1;
            end
            if (!any_v) begin
               if (on_v != 8'd0) begin
                  on_v = on_v - 8'd1;
               end
               if (on_v == 8'd0) begin
                  off_v  = min_gap_ff;
                  gate_v = 1'b0;
               end
            end else if (off_v == 8'd0) begin
               gate_v = 1'b1;
               if (on_v > release_hold_ff) begin
                  on_v = on_v - 8'd1;
               end
               if (on_v == 8'd0) begin
                  on_v = min_gap_ff;
               end
            end
         end

         button_level_in    = lvl_v;
         debounce_count_in  = deb_v;
         auto_flag_in       = auto_v;
         gate_on_in         = gate_v;
         element_running_in = run_v;
         on_count_in        = on_v;
         off_count_in       = off_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff          <= MIN_GAP_RST;
         release_hold_ff     <= RELEASE_HOLD_RST;
         debounce_ticks_ff   <= DEBOUNCE_TICKS_RST;
         tone_half_period_ff <= TONE_HALF_PERIOD_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_GAP:          min_gap_ff          <= csr_wdata[7:0];
            CSR_RELEASE_HOLD:     release_hold_ff     <= csr_wdata[7:0];
            CSR_DEBOUNCE_TICKS:   debounce_ticks_ff   <= csr_wdata[7:0];
            CSR_TONE_HALF_PERIOD: tone_half_period_ff <= csr_wdata[11:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_count_ff        <= 8'd0;
         off_count_ff       <= 8'd0;
         element_running_ff <= 1'b0;
         auto_flag_ff       <= 1'b1;
         dot_ticks_ff       <= DOT_TICKS_RST;
         dash_ticks_ff      <= DASH_TICKS_RST;
         button_level_ff    <= 1'b1;
         debounce_count_ff  <= 8'd0;
         gate_on_ff         <= 1'b1;
         tone_value_ff      <= TONE_HALF_PERIOD_RST;
         rsp_valid_ff       <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            on_count_ff        <= on_count_in;
            off_count_ff       <= off_count_in;
            element_running_ff <= element_running_in;
            auto_flag_ff       <= auto_flag_in;
            dot_ticks_ff       <= dot_ticks_in;
            dash_ticks_ff      <= dash_ticks_in;
            button_level_ff    <= button_level_in;
            debounce_count_ff  <= debounce_count_in;
            gate_on_ff         <= gate_on_in;
            tone_value_ff      <= tone_value_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff.key_down     <= gate_on_in;
         rsp_payload_ff.auto_mode    <= auto_flag_in;
         rsp_payload_ff.tone_compare <= tone_value_in;
         rsp_payload_ff.dot_length   <= dot_ticks_in;
      end
   end

   `MPK_ASSERT_NEXT(a_accept_gives_result, req_accept, rsp_valid_ff, "accepted request produced no result")
   `MPK_ASSERT_SAME(a_tone_nonzero, rsp_valid_ff, rsp_payload_ff.tone_compare != 12'd0, "tone compare reached zero")
   `MPK_ASSERT_SAME(a_dot_floor, rsp_valid_ff, rsp_payload_ff.dot_length >= DOT_BASE, "dot length below its floor")
   `MPK_ASSERT_NEXT(a_mode_only_on_request, !req_accept, $stable(auto_flag_ff), "mode changed without a request")

endmodule
